[src/smbpec_pkg.sv]
package smbpec_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEVICE_ADDRESS  = 2'd0,
        CFG_OBJECT_COMMAND  = 2'd1,
        CFG_AMBIENT_COMMAND = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_PEC_FAIL = 2'd1,
        STATUS_FAULT    = 2'd2,
        STATUS_RESERVED = 2'd3
    } status_t;

    localparam logic       MODE_READ  = 1'b0;
    localparam logic       MODE_WRITE = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RESET  = 7'd90;
    localparam logic [7:0] OBJECT_COMMAND_RESET  = 8'd7;
    localparam logic [7:0] AMBIENT_COMMAND_RESET = 8'd6;

    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [7:0]  CRC_INIT      = 8'h00;
    localparam logic [15:0] FAULT_MASK    = 16'h8000;
    localparam logic signed [17:0] KELVIN_OFFSET = 18'sd27315;

    // One byte of the SMBus PEC, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (crc[7])
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

[src/smbus_word_pec_check_and_build_core.sv]
// Pipeline: a transaction accepted at a clock edge is held in the input register; its
// result, with done high, is then loaded into the result register and shown on the outputs.
// Throughput: one transaction per cycle; busy is always low, the PEC over the frame
// is a flat XOR network between the input register and the result register.
// Reset: rst_n is asynchronous and active low; it clears the pipeline valid flags
// and loads the register defaults (address 90, commands 7 and 6).
module smbus_word_pec_check_and_build_core
    import smbpec_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic [7:0]                 command,
    input  logic [7:0]                 data_low,
    input  logic [7:0]                 data_high,
    input  logic [7:0]                 pec_in,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [15:0]                raw_value,
    output logic signed [17:0]         temp_centi_c,
    output logic [7:0]                 pec_out,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [6:0] device_address_reg;
    logic [7:0] object_command_reg;
    logic [7:0] ambient_command_reg;

    logic       valid_reg;
    logic       mode_reg;
    logic [7:0] command_reg;
    logic [7:0] data_low_reg;
    logic [7:0] data_high_reg;
    logic [7:0] pec_in_reg;

    logic              done_reg;
    status_t           status_reg;
    logic [15:0]       raw_value_reg;
    logic signed [17:0] temp_reg;
    logic [7:0]        pec_out_reg;

    status_t           status_next;
    logic [15:0]       raw_value_next;
    logic signed [17:0] temp_next;
    logic [7:0]        pec_out_next;

    logic [7:0]  write_addr;
    logic [7:0]  read_addr;
    logic [15:0] word;
    logic [7:0]  crc_head;
    logic [7:0]  crc_read;
    logic [7:0]  crc_write;
    logic        temp_command;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg  <= DEVICE_ADDRESS_RESET;
            object_command_reg  <= OBJECT_COMMAND_RESET;
            ambient_command_reg <= AMBIENT_COMMAND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS:  device_address_reg  <= cfg_data[6:0];
                CFG_OBJECT_COMMAND:  object_command_reg  <= cfg_data;
                CFG_AMBIENT_COMMAND: ambient_command_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= mode;
            command_reg   <= command;
            data_low_reg  <= data_low;
            data_high_reg <= data_high;
            pec_in_reg    <= pec_in;
        end
        if (valid_reg)
        begin
            status_reg    <= status_next;
            raw_value_reg <= raw_value_next;
            temp_reg      <= temp_next;
            pec_out_reg   <= pec_out_next;
        end
    end

    always_comb
    begin
        write_addr   = {device_address_reg, 1'b0};
        read_addr    = {device_address_reg, 1'b1};
        word         = {data_high_reg, data_low_reg};
        crc_head     = crc8_byte(crc8_byte(CRC_INIT, write_addr), command_reg);
        crc_read     = crc8_byte(crc8_byte(crc8_byte(crc_head, read_addr),
                                           data_low_reg), data_high_reg);
        crc_write    = crc8_byte(crc8_byte(crc_head, data_low_reg), data_high_reg);
        temp_command = (command_reg == object_command_reg) ||
                       (command_reg == ambient_command_reg);

        status_next    = STATUS_OK;
        raw_value_next = word;
        temp_next      = '0;
        pec_out_next   = crc_write;

        if (mode_reg == MODE_READ)
        begin
            pec_out_next = crc_read;
            if (crc_read != pec_in_reg)
            begin
                status_next    = STATUS_PEC_FAIL;
                raw_value_next = '0;
            end
            else if (temp_command && ((word & FAULT_MASK) != '0))
            begin
                status_next = STATUS_FAULT;
            end
            else
            begin
                temp_next = $signed({1'b0, word, 1'b0}) - KELVIN_OFFSET;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign raw_value    = raw_value_reg;
    assign temp_centi_c = temp_reg;
    assign pec_out      = pec_out_reg;

`ifndef ASSERT_OFF
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("Accepted transaction did not produce a result two cycles later.");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("Result strobe without an accepted transaction.");

    a_pec_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_PEC_FAIL) |-> (raw_value == '0 && temp_centi_c == '0))
        else $error("PEC mismatch result carries data.");

    a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FAULT) |-> (raw_value[15] && temp_centi_c == '0))
        else $error("Sensor fault result is inconsistent.");
`endif

endmodule
